FILE: rtl/cssm_pkg.sv
// ----------------------------------------------------------------------------
// cssm_pkg
// Shared event and action codes and the result word layout for the call
// session state machine.
// ----------------------------------------------------------------------------
package cssm_pkg;

  localparam int unsigned FUNC_W = 4;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned PH_W   = 4;

  // event kinds
  localparam logic [FUNC_W-1:0] FUNC_INITIATE   = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_PLAY       = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_DROP_REQ   = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_INIT_RESP  = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_ERROR      = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_REJECT     = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_DIALING    = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_RINGING    = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_CONNECTED  = 4'd8;
  localparam logic [FUNC_W-1:0] FUNC_FAILED     = 4'd9;
  localparam logic [FUNC_W-1:0] FUNC_LOST       = 4'd10;
  localparam logic [FUNC_W-1:0] FUNC_DROP_RESP  = 4'd11;
  localparam logic [FUNC_W-1:0] FUNC_PLAY_RESP  = 4'd12;
  localparam logic [FUNC_W-1:0] FUNC_DTMF       = 4'd13;

  // actions
  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FWD       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_APP       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DROP_REQ  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DROP_RESP = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REJECT    = 3'd5;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  req_id;
    logic [ID_W-1:0]  call_id;
    logic [ID_W-1:0]  busy_with_id;
    logic             register_call;
    logic             protocol_error;
    logic [PH_W-1:0]  session_state;
    logic             completed;
  } result_t;

endpackage

FILE: rtl/cssm_if.sv
// ----------------------------------------------------------------------------
// cssm_if
// Valid/ready channels of the call session state machine: event words in,
// result words out.
// ----------------------------------------------------------------------------
interface cssm_evt_if;
  logic                       valid;
  logic                       ready;
  logic [cssm_pkg::FUNC_W-1:0] func;
  logic [cssm_pkg::ID_W-1:0]   req_id;
  logic [cssm_pkg::ID_W-1:0]   call_id;

  modport source (output valid, output func, output req_id, output call_id, input ready);
  modport sink   (input valid, input func, input req_id, input call_id, output ready);
endinterface

interface cssm_res_if;
  logic                       valid;
  logic                       ready;
  logic [cssm_pkg::ACT_W-1:0] action;
  logic [cssm_pkg::ID_W-1:0]  out_req_id;
  logic [cssm_pkg::ID_W-1:0]  out_call_id;
  logic [cssm_pkg::ID_W-1:0]  busy_with_id;
  logic                       register_call;
  logic                       protocol_error;
  logic [cssm_pkg::PH_W-1:0]  session_state;
  logic                       completed;

  modport source (output valid, output action, output out_req_id, output out_call_id,
                  output busy_with_id, output register_call, output protocol_error,
                  output session_state, output completed, input ready);
  modport sink   (input valid, input action, input out_req_id, input out_call_id,
                  input busy_with_id, input register_call, input protocol_error,
                  input session_state, input completed, output ready);
endinterface

FILE: rtl/call_session_state_machine.sv
// ----------------------------------------------------------------------------
// call_session_state_machine
// Call-control engine for one session: one event word in, one result word
// out, with next phase, action, identifiers and a protocol-error flag.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake      | payload
//  in_ch    | in        | valid / ready  | func, req_id, call_id
//  out_ch   | out       | valid / ready  | action, ids, flags, session_state
//  cfg_*    | in        | cfg_wr_en      | cfg_wr_data = app_sink_enabled
//
//  One word per cycle sustained while out_ch takes each result word; an
//  event word passes the input register, then the result register. The phase
//  and pending-id update is a single pass of decode logic between those registers.
//  Reset (rst_n low, synchronous) puts the session in idle with no pending
//  id and enables the application sink.
//  A stalled result word holds the result register; the input register keeps
//  taking words until it is also full.
// ----------------------------------------------------------------------------
module call_session_state_machine (
  input  logic               clk,
  input  logic               rst_n,
  cssm_evt_if.sink           in_ch,
  cssm_res_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  typedef enum logic [cssm_pkg::PH_W-1:0] {
    PH_IDLE          = 4'd0,
    PH_WAIT_FREE     = 4'd1,
    PH_WAIT_INIT     = 4'd2,
    PH_WAIT_CONN     = 4'd3,
    PH_CONN          = 4'd4,
    PH_CONN_BUSY     = 4'd5,
    PH_WRONG_CONN    = 4'd6,
    PH_CXL_WAIT_INIT = 4'd7,
    PH_CXL_WAIT_CONN = 4'd8,
    PH_CXL_CONN      = 4'd9,
    PH_CXL_CONN_BUSY = 4'd10,
    PH_DONE          = 4'd11
  } phase_t;

  // input register
  logic                         in_v_r;
  logic [cssm_pkg::FUNC_W-1:0]  func_r;
  logic [cssm_pkg::ID_W-1:0]    rid_r;
  logic [cssm_pkg::ID_W-1:0]    cid_r;

  // session state
  phase_t                       phase_r;
  logic [cssm_pkg::ID_W-1:0]    pend_r;
  logic [cssm_pkg::ID_W-1:0]    call_r;
  logic                         app_en_r;

  // result register
  logic                         out_v_r;
  cssm_pkg::result_t            res_r;

  phase_t                       phase_nxt;
  logic [cssm_pkg::ID_W-1:0]    pend_nxt;
  logic [cssm_pkg::ID_W-1:0]    call_nxt;
  cssm_pkg::result_t            res_nxt;

  logic adv;
  logic in_take;

  assign adv     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_v_r || adv;

  // event decode
  always_comb begin
    logic                      can_set;
    logic                      can_take;
    logic                      resp_ok;
    logic                      err;
    logic [cssm_pkg::ACT_W-1:0] act;
    logic [cssm_pkg::ID_W-1:0]  orid;
    logic [cssm_pkg::ID_W-1:0]  ocid;
    logic [cssm_pkg::ID_W-1:0]  busy;
    logic                      reg_call;
    phase_t                    nph;

    can_set  = (pend_r == '0);
    can_take = (pend_r != '0);
    resp_ok  = can_take && (pend_r == rid_r);
    err      = 1'b0;
    act      = cssm_pkg::ACT_NONE;
    orid     = '0;
    ocid     = '0;
    busy     = '0;
    reg_call = 1'b0;
    nph      = phase_r;
    pend_nxt = pend_r;
    call_nxt = call_r;

    unique case (func_r)
      cssm_pkg::FUNC_INITIATE: begin
        if (phase_r == PH_IDLE && can_set) begin
          pend_nxt = rid_r; act = cssm_pkg::ACT_FWD; orid = rid_r; nph = PH_WAIT_INIT;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_PLAY: begin
        if (phase_r == PH_CONN && can_set) begin
          pend_nxt = rid_r; act = cssm_pkg::ACT_FWD; orid = rid_r; nph = PH_CONN_BUSY;
        end else if (phase_r == PH_CONN_BUSY) begin
          act = cssm_pkg::ACT_REJECT; orid = rid_r; busy = pend_r;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_DROP_REQ: begin
        if (phase_r == PH_IDLE || phase_r == PH_WAIT_FREE) begin
          act = cssm_pkg::ACT_DROP_RESP; orid = rid_r; nph = PH_DONE;
        end else if (phase_r == PH_WAIT_INIT && can_set) begin
          pend_nxt = rid_r; nph = PH_CXL_WAIT_INIT;
        end else if ((phase_r == PH_WAIT_CONN || phase_r == PH_CONN ||
                      phase_r == PH_CONN_BUSY) && can_set) begin
          pend_nxt = rid_r; act = cssm_pkg::ACT_FWD; orid = rid_r;
          nph = (phase_r == PH_WAIT_CONN) ? PH_CXL_WAIT_CONN :
                (phase_r == PH_CONN)      ? PH_CXL_CONN : PH_CXL_CONN_BUSY;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_INIT_RESP: begin
        if (phase_r == PH_WAIT_INIT && resp_ok) begin
          pend_nxt = '0; act = cssm_pkg::ACT_APP; orid = rid_r; call_nxt = cid_r;
          reg_call = 1'b1; ocid = cid_r; nph = PH_WAIT_CONN;
        end else if (phase_r == PH_CXL_WAIT_INIT && can_take) begin
          // cancelled before the response: tear the call down right away
          call_nxt = cid_r; act = cssm_pkg::ACT_DROP_REQ; orid = pend_r;
          ocid = cid_r; pend_nxt = '0; nph = PH_CXL_WAIT_CONN;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_ERROR: begin
        if (phase_r == PH_WAIT_INIT || phase_r == PH_CXL_WAIT_INIT) begin
          act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_DONE;
        end else if (phase_r == PH_CXL_CONN_BUSY) begin
          nph = PH_CXL_CONN;
        end else if (phase_r == PH_CONN_BUSY && resp_ok) begin
          pend_nxt = '0; act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_CONN;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_REJECT: begin
        if (phase_r == PH_WAIT_INIT && resp_ok) begin
          pend_nxt = '0; act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_DONE;
        end else if (phase_r == PH_CXL_WAIT_INIT) begin
          act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_DONE;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_DIALING, cssm_pkg::FUNC_RINGING: begin
        if (!(phase_r == PH_WAIT_CONN || phase_r == PH_CXL_WAIT_CONN)) err = 1'b1;
      end
      cssm_pkg::FUNC_CONNECTED: begin
        if (phase_r == PH_WAIT_CONN) begin
          act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_CONN;
        end else if (phase_r == PH_CXL_WAIT_CONN) begin
          nph = PH_WRONG_CONN;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_FAILED: begin
        if (phase_r == PH_WAIT_CONN) begin
          act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_DONE;
        end else if (phase_r == PH_CXL_WAIT_CONN && can_take) begin
          act = cssm_pkg::ACT_DROP_RESP; orid = pend_r; pend_nxt = '0; nph = PH_DONE;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_LOST: begin
        if (phase_r == PH_CONN || phase_r == PH_CONN_BUSY) begin
          act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_DONE;
        end else if ((phase_r == PH_CXL_CONN || phase_r == PH_CXL_CONN_BUSY ||
                      phase_r == PH_WRONG_CONN) && can_take) begin
          act = cssm_pkg::ACT_DROP_RESP; orid = pend_r; pend_nxt = '0; nph = PH_DONE;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_DROP_RESP: begin
        if (phase_r == PH_CXL_WAIT_INIT) begin
          act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_DONE;
        end else if ((phase_r == PH_WRONG_CONN || phase_r == PH_CXL_WAIT_CONN ||
                      phase_r == PH_CXL_CONN || phase_r == PH_CXL_CONN_BUSY) &&
                     resp_ok) begin
          pend_nxt = '0; act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_DONE;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_PLAY_RESP: begin
        if (phase_r == PH_CONN_BUSY && resp_ok) begin
          pend_nxt = '0; act = cssm_pkg::ACT_APP; orid = rid_r; nph = PH_CONN;
        end else if (phase_r == PH_CXL_CONN_BUSY) begin
          nph = PH_CXL_CONN;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_DTMF: begin
        if (phase_r == PH_CONN || phase_r == PH_CONN_BUSY) begin
          act = cssm_pkg::ACT_APP; orid = rid_r;
        end else if (!(phase_r == PH_CXL_CONN || phase_r == PH_CXL_CONN_BUSY ||
                       phase_r == PH_WRONG_CONN)) begin
          err = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase

    if (err) begin
      act      = cssm_pkg::ACT_NONE;
      orid     = '0;
      ocid     = '0;
      busy     = '0;
      reg_call = 1'b0;
      nph      = phase_r;
      pend_nxt = pend_r;
      call_nxt = call_r;
    end else if (!app_en_r && (act == cssm_pkg::ACT_APP || act == cssm_pkg::ACT_DROP_RESP ||
                               act == cssm_pkg::ACT_REJECT)) begin
      // application sink off: clear the action, request id and busy id; keep the state update
      act  = cssm_pkg::ACT_NONE;
      orid = '0;
      busy = '0;
    end

    phase_nxt              = nph;
    res_nxt.action         = act;
    res_nxt.req_id         = orid;
    res_nxt.call_id        = ocid;
    res_nxt.busy_with_id   = busy;
    res_nxt.register_call  = reg_call;
    res_nxt.protocol_error = err;
    res_nxt.session_state  = nph;
    res_nxt.completed      = (nph == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= PH_IDLE;
      pend_r   <= '0;
      call_r   <= '0;
      app_en_r <= 1'b1;
    end else begin
      if (cfg_wr_en) app_en_r <= cfg_wr_data;
      if (in_take) begin
        in_v_r <= 1'b1;
        func_r <= in_ch.func;
        rid_r  <= in_ch.req_id;
        cid_r  <= in_ch.call_id;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        res_r   <= res_nxt;
        phase_r <= phase_nxt;
        pend_r  <= pend_nxt;
        call_r  <= call_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.action         = res_r.action;
  assign out_ch.out_req_id     = res_r.req_id;
  assign out_ch.out_call_id    = res_r.call_id;
  assign out_ch.busy_with_id   = res_r.busy_with_id;
  assign out_ch.register_call  = res_r.register_call;
  assign out_ch.protocol_error = res_r.protocol_error;
  assign out_ch.session_state  = res_r.session_state;
  assign out_ch.completed      = res_r.completed;

  a_err_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_nxt.protocol_error) |=> (phase_r == $past(phase_r)) &&
                                        (pend_r == $past(pend_r)))
    else $error("protocol error changed session state");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.protocol_error) |-> (res_r.action == cssm_pkg::ACT_NONE) &&
                                          !res_r.register_call)
    else $error("protocol error word carries an action");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |=> (phase_r == PH_DONE))
    else $error("session left the done phase");

  a_state_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (res_r.session_state == phase_r) &&
            (res_r.completed == (phase_r == PH_DONE)))
    else $error("result phase differs from session phase");

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for call_session_state_machine. A short table of directed event
// words walks one session from idle to connected and covers several protocol
// error cases on that path. After that, random event words keep the session
// live for most of the run, and a last stretch lets it cancel and finish.
// Each accepted word is run through a local model of the session. Its result,
// or the table's fixed result for a fixed row, is queued and then compared
// with the next result word taken from the block. Both channels idle at
// random, and one long receiver hold fills up the block.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned REPORT_MAX     = 10;
  localparam logic [cssm_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = 4'd14;
  localparam logic [cssm_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

  typedef enum logic [cssm_pkg::PH_W-1:0] {
    PH_IDLE, PH_WAIT_FREE, PH_WAIT_INIT, PH_WAIT_CONN, PH_CONN, PH_CONN_BUSY,
    PH_WRONG_CONN, PH_CXL_WAIT_INIT, PH_CXL_WAIT_CONN, PH_CXL_CONN,
    PH_CXL_CONN_BUSY, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [cssm_pkg::FUNC_W-1:0] func;
    logic [cssm_pkg::ID_W-1:0]   req_id;
    logic [cssm_pkg::ID_W-1:0]   call_id;
  } call_event_t;

  typedef struct packed {
    logic [cssm_pkg::PH_W-1:0] phase;
    logic [cssm_pkg::ID_W-1:0] pending;
    logic [cssm_pkg::ID_W-1:0] call;
  } session_t;

  typedef struct packed {
    cssm_pkg::result_t res;
    session_t          nxt;
  } outcome_t;

  typedef struct packed {
    call_event_t       ev;
    logic              fixed;
    cssm_pkg::result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n, cfg_wr_en, cfg_wr_data;

  cssm_evt_if evt_ch();
  cssm_res_if res_ch();

  call_session_state_machine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (evt_ch),
    .out_ch      (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  session_t          sess;
  logic              app_sink_on;
  cssm_pkg::result_t awaited_results[$];
  row_t              directed_rows[$];
  int                send_idle_pct, recv_idle_pct;
  int                stall_requests;
  int                stall_served = 0;
  int                stall_left = 0;
  int                fault_count = 0;
  int                results_seen = 0;
  int                quiet_cycles = 0;

  always #1 clk = ~clk;

  // One transition of the session; errors leave the state untouched.
  function automatic outcome_t next_session(input session_t s, input logic sink_on,
                                            input call_event_t e);
    outcome_t o;
    logic     err, can_set, can_take, resp_ok;
    logic [cssm_pkg::PH_W-1:0] ph;
    ph       = s.phase;
    o.nxt    = s;
    o.res    = '0;
    err      = 1'b0;
    can_set  = (s.pending == '0);
    can_take = !can_set;
    resp_ok  = can_take && (s.pending == e.req_id);
    case (e.func)
      cssm_pkg::FUNC_INITIATE: begin
        if (ph == PH_IDLE && can_set) begin
          o.nxt.pending = e.req_id; o.res.action = cssm_pkg::ACT_FWD;
          o.res.req_id = e.req_id; o.nxt.phase = PH_WAIT_INIT;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_PLAY: begin
        if (ph == PH_CONN && can_set) begin
          o.nxt.pending = e.req_id; o.res.action = cssm_pkg::ACT_FWD;
          o.res.req_id = e.req_id; o.nxt.phase = PH_CONN_BUSY;
        end else if (ph == PH_CONN_BUSY) begin
          o.res.action = cssm_pkg::ACT_REJECT; o.res.req_id = e.req_id;
          o.res.busy_with_id = s.pending;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_DROP_REQ: begin
        if (ph == PH_IDLE || ph == PH_WAIT_FREE) begin
          o.res.action = cssm_pkg::ACT_DROP_RESP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_DONE;
        end else if (ph == PH_WAIT_INIT && can_set) begin
          o.nxt.pending = e.req_id; o.nxt.phase = PH_CXL_WAIT_INIT;
        end else if ((ph == PH_WAIT_CONN || ph == PH_CONN || ph == PH_CONN_BUSY) &&
                     can_set) begin
          o.nxt.pending = e.req_id; o.res.action = cssm_pkg::ACT_FWD;
          o.res.req_id = e.req_id;
          o.nxt.phase = (ph == PH_WAIT_CONN) ? PH_CXL_WAIT_CONN :
                        (ph == PH_CONN) ? PH_CXL_CONN : PH_CXL_CONN_BUSY;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_INIT_RESP: begin
        if (ph == PH_WAIT_INIT && resp_ok) begin
          o.nxt.pending = '0; o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.call = e.call_id; o.res.register_call = 1'b1; o.res.call_id = e.call_id;
          o.nxt.phase = PH_WAIT_CONN;
        end else if (ph == PH_CXL_WAIT_INIT && can_take) begin
          o.nxt.call = e.call_id; o.res.action = cssm_pkg::ACT_DROP_REQ;
          o.res.req_id = s.pending; o.res.call_id = e.call_id; o.nxt.pending = '0;
          o.nxt.phase = PH_CXL_WAIT_CONN;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_ERROR: begin
        if (ph == PH_WAIT_INIT || ph == PH_CXL_WAIT_INIT) begin
          o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_DONE;
        end else if (ph == PH_CXL_CONN_BUSY) begin
          o.nxt.phase = PH_CXL_CONN;
        end else if (ph == PH_CONN_BUSY && resp_ok) begin
          o.nxt.pending = '0; o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_CONN;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_REJECT: begin
        if (ph == PH_WAIT_INIT && resp_ok) begin
          o.nxt.pending = '0; o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_DONE;
        end else if (ph == PH_CXL_WAIT_INIT) begin
          o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_DONE;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_DIALING, cssm_pkg::FUNC_RINGING: begin
        if (!(ph == PH_WAIT_CONN || ph == PH_CXL_WAIT_CONN)) err = 1'b1;
      end
      cssm_pkg::FUNC_CONNECTED: begin
        if (ph == PH_WAIT_CONN) begin
          o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_CONN;
        end else if (ph == PH_CXL_WAIT_CONN) begin
          o.nxt.phase = PH_WRONG_CONN;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_FAILED: begin
        if (ph == PH_WAIT_CONN) begin
          o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_DONE;
        end else if (ph == PH_CXL_WAIT_CONN && can_take) begin
          o.res.action = cssm_pkg::ACT_DROP_RESP; o.res.req_id = s.pending;
          o.nxt.pending = '0; o.nxt.phase = PH_DONE;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_LOST: begin
        if (ph == PH_CONN || ph == PH_CONN_BUSY) begin
          o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_DONE;
        end else if ((ph == PH_CXL_CONN || ph == PH_CXL_CONN_BUSY || ph == PH_WRONG_CONN) &&
                     can_take) begin
          o.res.action = cssm_pkg::ACT_DROP_RESP; o.res.req_id = s.pending;
          o.nxt.pending = '0; o.nxt.phase = PH_DONE;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_DROP_RESP: begin
        if (ph == PH_CXL_WAIT_INIT) begin
          o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_DONE;
        end else if ((ph == PH_WRONG_CONN || ph == PH_CXL_WAIT_CONN || ph == PH_CXL_CONN ||
                      ph == PH_CXL_CONN_BUSY) && resp_ok) begin
          o.nxt.pending = '0; o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_DONE;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_PLAY_RESP: begin
        if (ph == PH_CONN_BUSY && resp_ok) begin
          o.nxt.pending = '0; o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
          o.nxt.phase = PH_CONN;
        end else if (ph == PH_CXL_CONN_BUSY) begin
          o.nxt.phase = PH_CXL_CONN;
        end else err = 1'b1;
      end
      cssm_pkg::FUNC_DTMF: begin
        if (ph == PH_CONN || ph == PH_CONN_BUSY) begin
          o.res.action = cssm_pkg::ACT_APP; o.res.req_id = e.req_id;
        end else if (!(ph == PH_CXL_CONN || ph == PH_CXL_CONN_BUSY || ph == PH_WRONG_CONN)) begin
          err = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase
    if (err) begin
      o.res = '0;
      o.res.protocol_error = 1'b1;
      o.nxt = s;
    end else if (!sink_on && (o.res.action == cssm_pkg::ACT_APP ||
                              o.res.action == cssm_pkg::ACT_DROP_RESP ||
                              o.res.action == cssm_pkg::ACT_REJECT)) begin
      // muted application sink: the call id and register flag still go out
      o.res.action = cssm_pkg::ACT_NONE; o.res.req_id = '0; o.res.busy_with_id = '0;
    end
    o.res.session_state = o.nxt.phase;
    o.res.completed = (o.nxt.phase == PH_DONE);
    return o;
  endfunction

  function automatic row_t ev_row(input logic [cssm_pkg::FUNC_W-1:0] f,
                                  input logic [cssm_pkg::ID_W-1:0] rid,
                                  input logic [cssm_pkg::ID_W-1:0] cid);
    row_t r;
    r = '0;
    r.ev.func = f; r.ev.req_id = rid; r.ev.call_id = cid;
    return r;
  endfunction

  function automatic row_t ev_fixed(input logic [cssm_pkg::FUNC_W-1:0] f,
                                    input logic [cssm_pkg::ID_W-1:0] rid,
                                    input logic [cssm_pkg::ID_W-1:0] cid,
                                    input logic [cssm_pkg::ACT_W-1:0] act,
                                    input logic [cssm_pkg::ID_W-1:0] orid,
                                    input logic [cssm_pkg::ID_W-1:0] ocid,
                                    input logic [cssm_pkg::ID_W-1:0] busy,
                                    input logic reg_call,
                                    input phase_t ph);
    row_t r;
    r = ev_row(f, rid, cid);
    r.fixed = 1'b1;
    r.res.action = act; r.res.req_id = orid; r.res.call_id = ocid;
    r.res.busy_with_id = busy; r.res.register_call = reg_call;
    r.res.session_state = ph; r.res.completed = (ph == PH_DONE);
    return r;
  endfunction

  function automatic row_t ev_error(input logic [cssm_pkg::FUNC_W-1:0] f,
                                    input logic [cssm_pkg::ID_W-1:0] rid,
                                    input logic [cssm_pkg::ID_W-1:0] cid,
                                    input phase_t ph);
    row_t r;
    r = ev_fixed(f, rid, cid, cssm_pkg::ACT_NONE, '0, '0, '0, 1'b0, ph);
    r.res.protocol_error = 1'b1;
    return r;
  endfunction

  function automatic call_event_t draw_event(input session_t s, input bit noise);
    call_event_t e;
    logic [31:0] pick;
    pick = noise ? $urandom_range(0, 15) : $urandom_range(0, 13);
    e.func = pick[cssm_pkg::FUNC_W-1:0];
    if (s.pending != '0 && $urandom_range(0, 99) < 60) e.req_id = s.pending;
    else begin
      case ($urandom_range(0, 9))
        0:       e.req_id = '0;
        1:       e.req_id = '1;
        default: e.req_id = $urandom;
      endcase
    end
    e.call_id = ($urandom_range(0, 9) == 0) ? '1 : $urandom;
    return e;
  endfunction

  // Present one event word; its expected result is queued at the accepting edge.
  task automatic offer_event(input call_event_t e, input logic fixed,
                             input cssm_pkg::result_t fixed_res);
    outcome_t o;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    evt_ch.valid   <= 1'b1;
    evt_ch.func    <= e.func;
    evt_ch.req_id  <= e.req_id;
    evt_ch.call_id <= e.call_id;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    o = next_session(sess, app_sink_on, e);
    sess = o.nxt;
    awaited_results.push_back(fixed ? fixed_res : o.res);
    @(negedge clk);
  endtask

  task automatic settle_idle();
    evt_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_app_sink(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    app_sink_on = v;
  endtask

  // Live stretches keep the session out of the cancel and done phases and
  // away from a busy call with no pending id, which would trap it.
  task automatic run_random(input int count, input bit allow_end, input int stall_at);
    call_event_t e;
    outcome_t    o;
    bit          noise, found;
    int          i, t, done_items;
    i = 0;
    done_items = 0;
    while (i < count && done_items <= 10) begin
      noise = ($urandom_range(0, 99) < 15);
      found = 1'b0;
      t = 0;
      while (!found && t < 16) begin
        e = draw_event(sess, noise);
        o = next_session(sess, app_sink_on, e);
        found = (noise || !o.res.protocol_error) &&
                (allow_end || (o.nxt.phase < PH_WRONG_CONN &&
                               !(o.nxt.phase == PH_CONN_BUSY && o.nxt.pending == '0)));
        t++;
      end
      if (!found) e.func = FUNC_UNUSED_HI;
      offer_event(e, 1'b0, '0);
      if (i == stall_at) stall_requests++;
      if (sess.phase == PH_DONE) done_items++;
      i++;
    end
  endtask

  // Receiver: random ready, or a long hold when one is requested.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left   <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    cssm_pkg::result_t got, want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.action         = res_ch.action;
      got.req_id         = res_ch.out_req_id;
      got.call_id        = res_ch.out_call_id;
      got.busy_with_id   = res_ch.busy_with_id;
      got.register_call  = res_ch.register_call;
      got.protocol_error = res_ch.protocol_error;
      got.session_state  = res_ch.session_state;
      got.completed      = res_ch.completed;
      results_seen++;
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("result word %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = awaited_results.pop_front();
        if (got.action !== want.action || got.req_id !== want.req_id ||
            got.call_id !== want.call_id || got.busy_with_id !== want.busy_with_id ||
            got.register_call !== want.register_call ||
            got.protocol_error !== want.protocol_error ||
            got.session_state !== want.session_state || got.completed !== want.completed) begin
          fault_count++;
          if (fault_count <= REPORT_MAX) begin
            $display("result word %0d wrong:", results_seen);
            $display("  exp act %0d rid %h cid %h busy %h reg %b err %b st %0d done %b",
                     want.action, want.req_id, want.call_id, want.busy_with_id,
                     want.register_call, want.protocol_error, want.session_state,
                     want.completed);
            $display("  got act %0d rid %h cid %h busy %h reg %b err %b st %0d done %b",
                     got.action, got.req_id, got.call_id, got.busy_with_id,
                     got.register_call, got.protocol_error, got.session_state,
                     got.completed);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("call_session_state_machine: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = 1'b0;
    evt_ch.valid = 1'b0; evt_ch.func = '0; evt_ch.req_id = '0; evt_ch.call_id = '0;
    sess = '0; app_sink_on = 1'b1;
    stall_requests = 0;
    send_idle_pct = 15; recv_idle_pct = 71;

    // idle errors, then one clean walk to a connected call with the id checks
    directed_rows.push_back(ev_error(FUNC_UNUSED_HI, '1, '1, PH_IDLE));
    directed_rows.push_back(ev_error(FUNC_UNUSED_LO, '0, '0, PH_IDLE));
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_DTMF, 32'h5, 32'h0, PH_IDLE));
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_INIT_RESP, '0, 32'h3, PH_IDLE));
    directed_rows.push_back(ev_fixed(cssm_pkg::FUNC_INITIATE, '1, '0, cssm_pkg::ACT_FWD,
                                     '1, '0, '0, 1'b0, PH_WAIT_INIT));
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_INITIATE, 32'h1, '0, PH_WAIT_INIT));
    // pending id already held
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_DROP_REQ, 32'h2, '0, PH_WAIT_INIT));
    // response id does not match pending
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_INIT_RESP, 32'hFFFF_FFFE, 32'h7,
                                     PH_WAIT_INIT));
    directed_rows.push_back(ev_fixed(cssm_pkg::FUNC_INIT_RESP, '1, '1, cssm_pkg::ACT_APP,
                                     '1, '1, '0, 1'b1, PH_WAIT_CONN));
    directed_rows.push_back(ev_row(cssm_pkg::FUNC_DIALING, 32'h3, 32'h8000_0000));
    directed_rows.push_back(ev_row(cssm_pkg::FUNC_RINGING, '0, '0));
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_PLAY, 32'h9, '0, PH_WAIT_CONN));
    directed_rows.push_back(ev_row(cssm_pkg::FUNC_CONNECTED, 32'h1234_5678, 32'h1));
    directed_rows.push_back(ev_row(cssm_pkg::FUNC_DTMF, 32'h8000_0000, '1));
    directed_rows.push_back(ev_row(cssm_pkg::FUNC_PLAY, 32'h100, '0));
    directed_rows.push_back(ev_fixed(cssm_pkg::FUNC_PLAY, 32'h55, '0, cssm_pkg::ACT_REJECT,
                                     32'h55, '0, 32'h100, 1'b0, PH_CONN_BUSY));
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_DROP_REQ, 32'h9, '0, PH_CONN_BUSY));
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_PLAY_RESP, 32'h101, '0, PH_CONN_BUSY));
    directed_rows.push_back(ev_row(cssm_pkg::FUNC_PLAY_RESP, 32'h100, '0));
    directed_rows.push_back(ev_row(cssm_pkg::FUNC_PLAY, 32'hAAAA_AAAA, 32'h5555_5555));
    directed_rows.push_back(ev_row(cssm_pkg::FUNC_ERROR, 32'hAAAA_AAAA, '0));
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_FAILED, 32'h1, '0, PH_CONN));
    directed_rows.push_back(ev_error(cssm_pkg::FUNC_DROP_RESP, 32'h2, '0, PH_CONN));
    directed_rows.push_back(ev_error(FUNC_UNUSED_HI, 32'h7FFF_FFFF, 32'h7FFF_FFFF, PH_CONN));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[k])
      offer_event(directed_rows[k].ev, directed_rows[k].fixed, directed_rows[k].res);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 15 : (p == 1) ? 71 : 0;
      recv_idle_pct = (p == 0) ? 71 : (p == 1) ? 15 : 0;
      settle_idle();
      set_app_sink(p == 1);
      run_random(370, 1'b0, (p == 2) ? 40 : -1);
    end

    // closing stretch: cancel paths and the done phase are open now
    settle_idle();
    set_app_sink(1'b1);
    run_random(80, 1'b1, -1);
    settle_idle();

    if (fault_count == 0 && awaited_results.size() == 0)
      $display("call_session_state_machine: match");
    else
      $display("call_session_state_machine: mismatch");
    $finish;
  end

endmodule
